// ----- design/pidaw_pkg.sv -----
// Package for the PID controller with anti-windup and derivative on measurement.
// Holds field widths, fixed-point constants and configuration register indexes.
// No dependencies.
package pidaw_pkg;

  localparam int TEMP_W  = 12;
  localparam int SP_W    = 8;
  localparam int GAIN_W  = 24;
  localparam int LIM_W   = 11;
  localparam int ERR_W   = 13;
  localparam int INTEG_W = 17;
  localparam int TFRAC_W = 4;
  localparam int PFRAC_W = 16;
  localparam int PE_W    = GAIN_W + 1 + ERR_W;
  localparam int PI_W    = GAIN_W + 1 + INTEG_W;
  localparam int ACC_W   = 44;
  localparam int CIDX_W  = 3;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 16;

  localparam logic [CIDX_W-1:0] REG_SETPOINT    = 3'd0;
  localparam logic [CIDX_W-1:0] REG_PROP_GAIN   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_INTEG_GAIN  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_DERIV_GAIN  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_UPPER_LIMIT = 3'd4;
  localparam logic [CIDX_W-1:0] REG_LOWER_LIMIT = 3'd5;

  localparam logic [SP_W-1:0]   SETPOINT_RST    = 8'd50;
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 24'd40960;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = 24'd41;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 24'd327680;
  localparam logic signed [LIM_W-1:0] UPPER_LIMIT_RST = 11'sd100;
  localparam logic signed [LIM_W-1:0] LOWER_LIMIT_RST = 11'sd0;

  localparam logic signed [ACC_W-1:0] ROUND_POS = 44'sd32768;
  localparam logic signed [ACC_W-1:0] ROUND_NEG = 44'sd32767;

endpackage

// ----- design/pid_anti_windup_controller.sv -----
// PID temperature controller with clamped integrator and derivative on measurement.
// Five-stage pipeline: sample, error/integrator, products, sum, clamp and round.
// Depends on pidaw_pkg.

// One drive value per measured sample, in order. The block takes one sample per
// clock cycle unless stalled and passes each through five pipeline registers
// (sample, error and integrator, the three gain products, their sum, the
// clamped and rounded result). Each stage holds its item while the next is
// full, so input stalls only when every stage is occupied. Integrator and
// previous sample update as an item leaves the first stage. Write registers
// only while no item is in flight.
module pid_anti_windup_controller (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [pidaw_pkg::S_TDATA_W-1:0]    s_tdata,   // [11:0] measured_temp
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [pidaw_pkg::M_TDATA_W-1:0]    m_tdata,   // [10:0] drive
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pidaw_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [pidaw_pkg::GAIN_W-1:0]       cfg_data
);

  import pidaw_pkg::*;

  logic [SP_W-1:0]          setpoint;
  logic [GAIN_W-1:0]        prop_gain;
  logic [GAIN_W-1:0]        integ_gain;
  logic [GAIN_W-1:0]        deriv_gain;
  logic signed [LIM_W-1:0]  upper_limit;
  logic signed [LIM_W-1:0]  lower_limit;

  logic signed [INTEG_W-1:0] integrator;
  logic signed [INTEG_W-1:0] integrator_next;
  logic [TEMP_W-1:0]         previous_temp;

  logic                      a_valid, b_valid, c_valid, d_valid;
  logic                      a_ready, b_ready, c_ready, d_ready, e_ready;
  logic [TEMP_W-1:0]         a_meas;
  logic signed [ERR_W-1:0]   b_err, b_delta;
  logic signed [INTEG_W-1:0] b_integ;
  logic signed [PE_W-1:0]    c_p, c_d;
  logic signed [PI_W-1:0]    c_i;
  logic signed [ACC_W-1:0]   d_acc;
  logic signed [LIM_W-1:0]   drive;

  logic signed [ERR_W-1:0]   err, delta;
  logic signed [INTEG_W:0]   isum, ihi, ilo;
  logic signed [PE_W-1:0]    p_prod, d_prod;
  logic signed [PI_W-1:0]    i_prod;
  logic signed [ACC_W-1:0]   acc, acc_hi, acc_lo, acc_clamp, acc_round;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint    <= SETPOINT_RST;
      prop_gain   <= PROP_GAIN_RST;
      integ_gain  <= INTEG_GAIN_RST;
      deriv_gain  <= DERIV_GAIN_RST;
      upper_limit <= UPPER_LIMIT_RST;
      lower_limit <= LOWER_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SETPOINT:    setpoint    <= cfg_data[SP_W-1:0];
        REG_PROP_GAIN:   prop_gain   <= cfg_data;
        REG_INTEG_GAIN:  integ_gain  <= cfg_data;
        REG_DERIV_GAIN:  deriv_gain  <= cfg_data;
        REG_UPPER_LIMIT: upper_limit <= $signed(cfg_data[LIM_W-1:0]);
        REG_LOWER_LIMIT: lower_limit <= $signed(cfg_data[LIM_W-1:0]);
        default: ;
      endcase
    end
  end

  assign e_ready  = !m_tvalid || m_tready;
  assign d_ready  = !d_valid || e_ready;
  assign c_ready  = !c_valid || d_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign s_tready = a_ready;

  always_comb begin
    err   = $signed({1'b0, setpoint, {TFRAC_W{1'b0}}}) - $signed({1'b0, a_meas});
    delta = $signed({1'b0, a_meas}) - $signed({1'b0, previous_temp});
    isum  = (INTEG_W+1)'(integrator) + (INTEG_W+1)'(err);
    ihi   = (INTEG_W+1)'($signed({upper_limit, {TFRAC_W{1'b0}}}));
    ilo   = (INTEG_W+1)'($signed({lower_limit, {TFRAC_W{1'b0}}}));
    if (isum > ihi) begin
      integrator_next = ihi[INTEG_W-1:0];
    end else if (isum < ilo) begin
      integrator_next = ilo[INTEG_W-1:0];
    end else begin
      integrator_next = isum[INTEG_W-1:0];
    end
  end

  always_comb begin
    p_prod = $signed({1'b0, prop_gain}) * b_err;
    i_prod = $signed({1'b0, integ_gain}) * b_integ;
    d_prod = $signed({1'b0, deriv_gain}) * b_delta;
  end

  always_comb begin
    acc    = ACC_W'(c_p) + ACC_W'(c_i) - ACC_W'(c_d);
  end

  always_comb begin
    acc_hi = ACC_W'($signed({upper_limit, {PFRAC_W{1'b0}}}));
    acc_lo = ACC_W'($signed({lower_limit, {PFRAC_W{1'b0}}}));
    if (d_acc > acc_hi) begin
      acc_clamp = acc_hi;
    end else if (d_acc < acc_lo) begin
      acc_clamp = acc_lo;
    end else begin
      acc_clamp = d_acc;
    end
    acc_round = (acc_clamp + (acc_clamp[ACC_W-1] ? ROUND_NEG : ROUND_POS)) >>> PFRAC_W;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid       <= 1'b0;
      b_valid       <= 1'b0;
      c_valid       <= 1'b0;
      d_valid       <= 1'b0;
      m_tvalid      <= 1'b0;
      integrator    <= '0;
      previous_temp <= '0;
    end else begin
      if (a_ready) a_valid <= s_tvalid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
      if (d_ready) d_valid <= c_valid;
      if (e_ready) m_tvalid <= d_valid;
      if (a_valid && b_ready) begin
        integrator    <= integrator_next;
        previous_temp <= a_meas;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && s_tvalid) a_meas <= s_tdata[TEMP_W-1:0];
    if (b_ready && a_valid) begin
      b_err   <= err;
      b_delta <= delta;
      b_integ <= integrator_next;
    end
    if (c_ready && b_valid) begin
      c_p <= p_prod;
      c_i <= i_prod;
      c_d <= d_prod;
    end
    if (d_ready && c_valid) d_acc <= acc;
    if (e_ready && d_valid) drive <= acc_round[LIM_W-1:0];
  end

  assign m_tdata = {{(M_TDATA_W-LIM_W){1'b0}}, drive};

`ifndef SYNTHESIS
  a_prev_follows: assert property (@(posedge clk) disable iff (rst)
    (a_valid && b_ready) |=> (previous_temp == $past(a_meas)))
    else $error("previous sample not taken from departing item");

  a_integ_bounded: assert property (@(posedge clk) disable iff (rst)
    (a_valid && b_ready && (lower_limit <= upper_limit)) |=>
      ((integrator <= $past(ihi)) && (integrator >= $past(ilo))))
    else $error("integrator outside limits");

  a_drive_bounded: assert property (@(posedge clk) disable iff (rst)
    (d_valid && e_ready && (lower_limit <= upper_limit)) |=>
      ((drive <= $past(upper_limit)) && (drive >= $past(lower_limit))))
    else $error("drive outside limits");
`endif

endmodule
